// File: src/fpls_pkg.sv
// Package for the front panel LED and switch scanner.
// Matrix sizes, field widths, operation and register codes, and shared structs.
// No dependencies; every other file of the scanner imports this package.
package fpls_pkg;

	// Matrix geometry
	localparam int LED_ROWS    = 8;
	localparam int SWITCH_ROWS = 3;
	localparam int COLUMNS     = 12;

	// Scan sequence: on/gap pairs for each LED row, then one settle phase per switch row
	localparam int LED_PHASES = 2 * LED_ROWS;
	localparam int NUM_PHASES = LED_PHASES + SWITCH_ROWS;
	localparam int PHASE_W    = $clog2(NUM_PHASES);
	localparam int LROW_W     = (LED_ROWS > 1) ? $clog2(LED_ROWS) : 1;
	localparam int SROW_W     = (SWITCH_ROWS > 1) ? $clog2(SWITCH_ROWS) : 1;

	// Field widths
	localparam int ACT_W      = 2;
	localparam int ROW_W      = 3;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Deposit switch position
	localparam int DEP_ROW = 2;
	localparam int DEP_BIT = 9;

	// Register reset values
	localparam logic [TICK_W-1:0] LED_ON_RESET = TICK_W'(300);
	localparam logic [TICK_W-1:0] ROW_GAP_RESET = TICK_W'(10);
	localparam logic [TICK_W-1:0] SETTLE_RESET = TICK_W'(3);

	// Transaction operations
	typedef enum logic [ACT_W-1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LED_ON  = 2'd0,
		CFG_ROW_GAP = 2'd1,
		CFG_SETTLE  = 2'd2
	} cfg_reg_t;

	// Deposit switch handling, decided after the first full scan
	typedef enum logic [1:0] {
		DEP_NORMAL  = 2'd0,
		DEP_INVERT  = 2'd1,
		DEP_UNKNOWN = 2'd2
	} dep_mode_t;

	// Current scan position, timer to store
	typedef struct packed {
		logic              led_phase;
		logic              led_lit;
		logic [LROW_W-1:0] led_row;
		logic              sw_phase;
		logic [SROW_W-1:0] sw_row;
		logic              sample;
		logic              last_phase;
	} scan_t;

	// One result transaction
	typedef struct packed {
		logic [COLUMNS-1:0]     column_drive;
		logic                   columns_driven;
		logic [LED_ROWS-1:0]    led_row_on;
		logic [SWITCH_ROWS-1:0] switch_row_sink;
		logic [COLUMNS-1:0]     switch_state;
		logic [COLUMNS-1:0]     switch_events;
	} res_t;

endpackage

// File: src/fpls_if.sv
// Channel interfaces of the scanner: command channel in, result channel out.
// Valid/ready handshake; depends on fpls_pkg.
interface fpls_in_if;
	import fpls_pkg::*;

	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [ROW_W-1:0]   row_index;
	logic [COLUMNS-1:0] led_bits;
	logic [COLUMNS-1:0] column_sense;

	modport source (output valid, action, row_index, led_bits, column_sense, input ready);
	modport sink (input valid, action, row_index, led_bits, column_sense, output ready);
endinterface

interface fpls_out_if;
	import fpls_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [COLUMNS-1:0]     column_drive;
	logic                   columns_driven;
	logic [LED_ROWS-1:0]    led_row_on;
	logic [SWITCH_ROWS-1:0] switch_row_sink;
	logic [COLUMNS-1:0]     switch_state;
	logic [COLUMNS-1:0]     switch_events;

	modport source (output valid, column_drive, columns_driven, led_row_on, switch_row_sink,
		switch_state, switch_events, input ready);
	modport sink (input valid, column_drive, columns_driven, led_row_on, switch_row_sink,
		switch_state, switch_events, output ready);
endinterface

// File: src/fpls_scan_timer.sv
// Scan sequencer: phase and tick counters plus the three timing registers.
// Decodes the current phase for the stores; depends on fpls_pkg.
module fpls_scan_timer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic                             cfg_we,
	input  logic [fpls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpls_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fpls_pkg::scan_t                  scan
);
	import fpls_pkg::*;

	logic [TICK_W-1:0]  led_on_q;
	logic [TICK_W-1:0]  gap_q;
	logic [TICK_W-1:0]  settle_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TICK_W-1:0]  ticks_q;

	logic               in_range;
	logic               is_gap;
	logic [TICK_W-1:0]  phase_len;
	logic               phase_end;
	logic [PHASE_W-1:0] step_one;
	logic [PHASE_W-1:0] step_two;
	logic [PHASE_W-1:0] phase_next;

	// Write timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_on_q <= LED_ON_RESET;
			gap_q    <= ROW_GAP_RESET;
			settle_q <= SETTLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LED_ON:  led_on_q <= TICK_W'(cfg_data);
				CFG_ROW_GAP: gap_q    <= TICK_W'(cfg_data);
				CFG_SETTLE:  settle_q <= TICK_W'(cfg_data);
				default:     ;
			endcase
		end
	end

	// Decode current phase
	always_comb begin
		in_range        = phase_q < PHASE_W'(NUM_PHASES);
		scan.led_phase  = phase_q < PHASE_W'(LED_PHASES);
		is_gap          = scan.led_phase && phase_q[0];
		scan.led_lit    = scan.led_phase && !phase_q[0];
		scan.led_row    = LROW_W'(phase_q >> 1);
		scan.sw_phase   = in_range && !scan.led_phase;
		scan.sw_row     = SROW_W'(phase_q - PHASE_W'(LED_PHASES));
		scan.last_phase = phase_q == PHASE_W'(NUM_PHASES - 1);
		scan.sample     = scan.sw_phase && phase_end;
	end

	// Phase length; on and settle times of zero count as one tick
	always_comb begin
		if (is_gap) begin
			phase_len = gap_q;
		end else if (phase_q < PHASE_W'(LED_PHASES)) begin
			phase_len = (led_on_q == '0) ? TICK_W'(1) : led_on_q;
		end else begin
			phase_len = (settle_q == '0) ? TICK_W'(1) : settle_q;
		end
		phase_end   = ({1'b0, ticks_q} + 1'b1) >= {1'b0, phase_len};
	end

	// Next phase: wrap after the last switch row, skip empty gaps
	always_comb begin
		step_one = phase_q + 1'b1;
		if (step_one >= PHASE_W'(NUM_PHASES)) begin
			step_one = '0;
		end
		step_two = step_one;
		if (step_one < PHASE_W'(LED_PHASES) && step_one[0] && gap_q == '0) begin
			step_two = step_one + 1'b1;
		end
		phase_next = (step_two >= PHASE_W'(NUM_PHASES)) ? '0 : step_two;
	end

	// Advance counters once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			ticks_q <= '0;
		end else if (advance) begin
			if (!in_range) begin
				phase_q <= '0;
				ticks_q <= '0;
			end else if (phase_end) begin
				phase_q <= phase_next;
				ticks_q <= '0;
			end else begin
				ticks_q <= ticks_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PHASE_W'(NUM_PHASES))
		else $error("scan phase out of range");

	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range && !phase_end |=> ticks_q == $past(ticks_q) + 1'b1)
		else $error("tick counter failed to advance");

	a_gap_skip: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_end && gap_q == '0 |=>
		!(phase_q < PHASE_W'(LED_PHASES) && phase_q[0]))
		else $error("entered an empty gap phase");
`endif

endmodule

// File: src/fpls_matrix_store.sv
// LED pattern store, switch and event stores, and the deposit switch mode.
// Serves writes, clear-on-read and end-of-settle sampling; depends on fpls_pkg.
module fpls_matrix_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [fpls_pkg::ACT_W-1:0]      action,
	input  logic [fpls_pkg::ROW_W-1:0]      row_index,
	input  logic [fpls_pkg::COLUMNS-1:0]    led_bits,
	input  logic [fpls_pkg::COLUMNS-1:0]    column_sense,
	input  fpls_pkg::scan_t                 scan,
	output logic [fpls_pkg::COLUMNS-1:0]    led_pattern,
	output logic [fpls_pkg::COLUMNS-1:0]    read_state,
	output logic [fpls_pkg::COLUMNS-1:0]    read_events
);
	import fpls_pkg::*;

	localparam logic [COLUMNS-1:0] DEP_MASK = COLUMNS'(1) << DEP_BIT;

	logic [COLUMNS-1:0] led_q [LED_ROWS];
	logic [COLUMNS-1:0] sw_q [SWITCH_ROWS];
	logic [COLUMNS-1:0] ev_q [SWITCH_ROWS];
	dep_mode_t          mode_q;

	logic               do_write;
	logic               do_read;
	logic               do_sample;
	logic [COLUMNS-1:0] scan_bits;
	logic [COLUMNS-1:0] closed;
	logic [COLUMNS-1:0] sw_next [SWITCH_ROWS];
	logic [COLUMNS-1:0] ev_next [SWITCH_ROWS];

	// Decode the transaction
	always_comb begin
		do_write  = advance && action == ACT_WRITE && {1'b0, row_index} < (ROW_W+1)'(LED_ROWS);
		do_read   = action == ACT_READ && {1'b0, row_index} < (ROW_W+1)'(SWITCH_ROWS);
		do_sample = advance && scan.sample;
	end

	// Read ports: pattern of the active LED row, switch row being read
	always_comb begin
		led_pattern = led_q[scan.led_row];
		read_state  = do_read ? sw_q[SROW_W'(row_index)] : '0;
		read_events = do_read ? ev_q[SROW_W'(row_index)] : '0;
	end

	// Sample columns, flipping the deposit bit when inverted
	always_comb begin
		scan_bits = column_sense;
		if (int'(scan.sw_row) == DEP_ROW && mode_q == DEP_INVERT) begin
			scan_bits = column_sense ^ DEP_MASK;
		end
		closed = ~scan_bits;
		for (int r = 0; r < SWITCH_ROWS; r++) begin
			sw_next[r] = sw_q[r];
			ev_next[r] = ev_q[r];
			if (advance && do_read && int'(row_index) == r) begin
				ev_next[r] = '0;
			end
			if (do_sample && int'(scan.sw_row) == r) begin
				ev_next[r] = ev_next[r] | (closed & ~sw_q[r]);
				sw_next[r] = closed;
			end
		end
	end

	// Hold LED patterns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < LED_ROWS; r++) begin
				led_q[r] <= '0;
			end
		end else if (do_write) begin
			led_q[LROW_W'(row_index)] <= led_bits;
		end
	end

	// Update switch and event rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < SWITCH_ROWS; r++) begin
				sw_q[r] <= '0;
				ev_q[r] <= '0;
			end
		end else begin
			for (int r = 0; r < SWITCH_ROWS; r++) begin
				sw_q[r] <= sw_next[r];
				ev_q[r] <= ev_next[r];
			end
		end
	end

	// Latch deposit mode at the end of the first full scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= DEP_UNKNOWN;
		end else if (do_sample && scan.last_phase && mode_q != DEP_NORMAL
			&& mode_q != DEP_INVERT) begin
			mode_q <= sw_next[DEP_ROW][DEP_BIT] ? DEP_INVERT : DEP_NORMAL;
		end
	end

endmodule

// File: src/fpls_out_buffer.sv
// Two-entry result buffer between the result logic and the output channel.
// Keeps the input side open while a result waits; depends on fpls_pkg, fpls_if.
module fpls_out_buffer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpls_pkg::res_t  push_data,
	output logic            space,
	fpls_out_if.source      out_ch
);
	import fpls_pkg::*;

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	res_t       head;

	assign space = count_q != 2'd2;
	assign pop   = out_ch.valid && out_ch.ready;
	assign head  = mem_q[rd_ptr_q];

	// Store result transactions
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Drive the output channel from the head entry
	always_comb begin
		out_ch.valid           = count_q != '0;
		out_ch.column_drive    = head.column_drive;
		out_ch.columns_driven  = head.columns_driven;
		out_ch.led_row_on      = head.led_row_on;
		out_ch.switch_row_sink = head.switch_row_sink;
		out_ch.switch_state    = head.switch_state;
		out_ch.switch_events   = head.switch_events;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result buffer overflow");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("result buffer lost track of a pop");
`endif

endmodule

// File: src/front_panel_led_switch_scanner.sv
// Top level of the front panel LED and switch scanner.
// Instantiates the scan timer, matrix store and result buffer; depends on fpls_pkg, fpls_if.
//
// Every accepted command transaction is one scan tick and returns exactly one result
// transaction. The block takes one transaction per clock while in_ch.ready is high: the
// result is formed in the same cycle from the current scan phase and stores and is
// registered in a two-entry output buffer, behind any result still waiting. in_ch.ready
// drops only while both buffer entries are waiting to be taken. LED rows are each lit
// for led_on_ticks and blanked for row_gap_ticks, then each switch row is sunk for
// switch_settle_ticks and sampled on its last tick; timing registers may be written
// only while no transaction is outstanding.
module front_panel_led_switch_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fpls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpls_pkg::CFG_DATA_W-1:0] cfg_data,
	fpls_in_if.sink                         in_ch,
	fpls_out_if.source                      out_ch
);
	import fpls_pkg::*;

	logic               accept;
	logic               space;
	scan_t              scan;
	logic [COLUMNS-1:0] led_pattern;
	logic [COLUMNS-1:0] read_state;
	logic [COLUMNS-1:0] read_events;
	res_t               result;

	assign in_ch.ready = space;
	assign accept      = in_ch.valid && space;

	fpls_scan_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.scan      (scan)
	);

	fpls_matrix_store u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.action       (in_ch.action),
		.row_index    (in_ch.row_index),
		.led_bits     (in_ch.led_bits),
		.column_sense (in_ch.column_sense),
		.scan         (scan),
		.led_pattern  (led_pattern),
		.read_state   (read_state),
		.read_events  (read_events)
	);

	// Form the result from the phase at the start of the tick
	always_comb begin
		result.column_drive    = scan.led_phase ? ~led_pattern : '0;
		result.columns_driven  = scan.led_phase;
		result.led_row_on      = scan.led_lit ? (LED_ROWS'(1) << scan.led_row) : '0;
		result.switch_row_sink = scan.sw_phase ? (SWITCH_ROWS'(1) << scan.sw_row) : '0;
		result.switch_state    = read_state;
		result.switch_events   = read_events;
	end

	fpls_out_buffer u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.space     (space),
		.out_ch    (out_ch)
	);

endmodule

// File: verif/panel_scan_checker.sv
// Checker for the front panel scanner: watches the command and result channels,
// keeps its own model of the scan and compares every result transaction field by field.
// Depends on fpls_pkg and on the channel interfaces in fpls_if.
module panel_scan_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fpls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpls_pkg::CFG_DATA_W-1:0] cfg_data,
	fpls_in_if                              in_ch,
	fpls_out_if                             out_ch,
	output int                              failures,
	output int                              waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import fpls_pkg::*;

	// Timing register copies
	logic [TICK_W-1:0]  on_len;
	logic [TICK_W-1:0]  gap_len;
	logic [TICK_W-1:0]  settle_len;

	// Panel state as the block should hold it
	logic [COLUMNS-1:0] led_pattern [LED_ROWS];
	logic [COLUMNS-1:0] sw_closed [SWITCH_ROWS];
	logic [COLUMNS-1:0] sw_rose [SWITCH_ROWS];
	int unsigned        scan_pos;
	int unsigned        pos_ticks;
	dep_mode_t          deposit_mode;

	res_t               panel_due [$];
	int                 fail_count;
	int                 result_count;

	// Print one line per failure and count it
	task automatic report_mismatch(string msg);
		$display("[%0t] scanner mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got)
			report_mismatch($sformatf("result %0d %s expected 0x%0h got 0x%0h",
				result_count, name, want, got));
	endtask

	// Length of a scan position in ticks; only a gap may be zero
	function automatic int unsigned dwell(int unsigned pos);
		int unsigned len;
		if (pos < LED_PHASES)
			len = (pos % 2 == 1) ? gap_len : on_len;
		else
			len = settle_len;
		if (len == 0 && !(pos < LED_PHASES && pos % 2 == 1))
			len = 1;
		return len;
	endfunction

	// Sample the column pins of one switch row, flagging new closures
	function automatic void capture_row(int unsigned row, logic [COLUMNS-1:0] sense);
		logic [COLUMNS-1:0] level;
		logic [COLUMNS-1:0] closed;
		level = sense;
		if (row == DEP_ROW && deposit_mode == DEP_INVERT)
			level[DEP_BIT] = ~level[DEP_BIT];
		closed = ~level;
		sw_rose[row] = sw_rose[row] | (closed & ~sw_closed[row]);
		sw_closed[row] = closed;
	endfunction

	// Move to the next scan position, skipping gaps of zero length
	function automatic void advance_scan();
		int unsigned pos;
		pos = scan_pos + 1;
		if (pos >= NUM_PHASES)
			pos = 0;
		if (pos < LED_PHASES && pos % 2 == 1 && gap_len == 0)
			pos++;
		scan_pos = pos;
		pos_ticks = 0;
	endfunction

	// Work out the panel outputs for one command, then apply it and count the tick
	function automatic res_t predict_panel(logic [ACT_W-1:0] act, logic [ROW_W-1:0] row,
		logic [COLUMNS-1:0] bits, logic [COLUMNS-1:0] sense);
		res_t r;
		r = '0;
		if (scan_pos < LED_PHASES) begin
			r.columns_driven = 1'b1;
			r.column_drive = ~led_pattern[scan_pos / 2];
			if (scan_pos % 2 == 0)
				r.led_row_on[scan_pos / 2] = 1'b1;
		end else begin
			r.switch_row_sink[scan_pos - LED_PHASES] = 1'b1;
		end

		if (act == ACT_WRITE && row < LED_ROWS) begin
			led_pattern[row] = bits;
		end else if (act == ACT_READ && row < SWITCH_ROWS) begin
			r.switch_state = sw_closed[row];
			r.switch_events = sw_rose[row];
			sw_rose[row] = '0;
		end

		if (pos_ticks + 1 >= dwell(scan_pos)) begin
			if (scan_pos >= LED_PHASES) begin
				capture_row(scan_pos - LED_PHASES, sense);
				// Latch the deposit switch handling at the end of the first full scan
				if (scan_pos == NUM_PHASES - 1 && deposit_mode == DEP_UNKNOWN)
					deposit_mode = sw_closed[DEP_ROW][DEP_BIT] ? DEP_INVERT : DEP_NORMAL;
			end
			advance_scan();
		end else begin
			pos_ticks = pos_ticks + 1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			on_len = LED_ON_RESET;
			gap_len = ROW_GAP_RESET;
			settle_len = SETTLE_RESET;
			for (int i = 0; i < LED_ROWS; i++)
				led_pattern[i] = '0;
			for (int i = 0; i < SWITCH_ROWS; i++) begin
				sw_closed[i] = '0;
				sw_rose[i] = '0;
			end
			scan_pos = 0;
			pos_ticks = 0;
			deposit_mode = DEP_UNKNOWN;
			panel_due.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_LED_ON:  on_len = cfg_data;
					CFG_ROW_GAP: gap_len = cfg_data;
					CFG_SETTLE:  settle_len = cfg_data;
					default: ;
				endcase
			end

			// Predict each accepted command transaction
			if (in_ch.valid && in_ch.ready)
				panel_due.push_back(predict_panel(in_ch.action, in_ch.row_index,
					in_ch.led_bits, in_ch.column_sense));

			// Compare each accepted result transaction with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				if (panel_due.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						result_count));
				end else begin
					want = panel_due.pop_front();
					check_field("column_drive", want.column_drive, out_ch.column_drive);
					check_field("columns_driven", want.columns_driven, out_ch.columns_driven);
					check_field("led_row_on", want.led_row_on, out_ch.led_row_on);
					check_field("switch_row_sink", want.switch_row_sink, out_ch.switch_row_sink);
					check_field("switch_state", want.switch_state, out_ch.switch_state);
					check_field("switch_events", want.switch_events, out_ch.switch_events);
				end
				result_count++;
			end
		end
		failures <= fail_count;
		waiting <= panel_due.size();
	end

endmodule

// File: verif/front_panel_led_switch_scanner_test.sv
// Testbench top for the front panel scanner: clock, reset, timing register sweeps,
// command and result traffic with random idling, and the final verdict.
// Depends on fpls_pkg, fpls_if, panel_scan_checker and the scanner itself.
module front_panel_led_switch_scanner_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fpls_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PLANS = 8;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    failures;
	int                    waiting;
	int                    cycle_count;

	int                    tx_idle_pct;
	int                    rx_idle_pct;
	int                    n_items;
	int                    n_writes;
	int                    n_reads;
	int                    n_absent;
	int                    n_settings;

	// Timing settings swept after the directed part: on, gap, settle, commands
	int unsigned plan_on     [PLANS] = '{0, 1, 3, 5, 65535, 2, 1, 4};
	int unsigned plan_gap    [PLANS] = '{0, 1, 2, 0, 65535, 65535, 0, 1};
	int unsigned plan_settle [PLANS] = '{0, 1, 4, 2, 65535, 1, 65535, 3};
	int unsigned plan_items  [PLANS] = '{280, 280, 300, 300, 100, 150, 150, 300};

	fpls_in_if  cmd_ch ();
	fpls_out_if res_ch ();

	front_panel_led_switch_scanner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (cmd_ch),
		.out_ch    (res_ch)
	);

	panel_scan_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (cmd_ch),
		.out_ch    (res_ch),
		.failures  (failures),
		.waiting   (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a run that hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding", cycle_count, waiting);
		$display("FAILURE");
		$finish;
	end

	// Result side: stall at random
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one command transaction, idling at random first, and hold it until taken
	task automatic send_item(logic [ACT_W-1:0] act, logic [ROW_W-1:0] row,
		logic [COLUMNS-1:0] bits, logic [COLUMNS-1:0] sense);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.row_index <= row;
		cmd_ch.led_bits <= bits;
		cmd_ch.column_sense <= sense;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		n_items++;
		if (act == ACT_WRITE)
			n_writes++;
		if (act == ACT_READ) begin
			n_reads++;
			if (row >= SWITCH_ROWS)
				n_absent++;
		end
	endtask

	// Drop valid and wait until every result has come back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (waiting != 0);
	endtask

	// Load all three timing registers on consecutive edges
	task automatic write_timing(int unsigned on_t, int unsigned gap_t, int unsigned settle_t);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LED_ON;
		cfg_data <= CFG_DATA_W'(on_t);
		@(posedge clk);
		cfg_index <= CFG_ROW_GAP;
		cfg_data <= CFG_DATA_W'(gap_t);
		@(posedge clk);
		cfg_index <= CFG_SETTLE;
		cfg_data <= CFG_DATA_W'(settle_t);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	initial begin
		logic [ACT_W-1:0]   act;
		logic [ROW_W-1:0]   row;
		logic [COLUMNS-1:0] bits;
		logic [COLUMNS-1:0] sense;
		logic [COLUMNS-1:0] held_sense;
		int                 roll;
		int                 done;
		int                 total;

		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LED_ON;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_TICK;
		cmd_ch.row_index <= '0;
		cmd_ch.led_bits <= '0;
		cmd_ch.column_sense <= '1;
		tx_idle_pct = 7;
		rx_idle_pct = 72;
		n_items = 0;
		n_writes = 0;
		n_reads = 0;
		n_absent = 0;
		n_settings = 0;
		held_sense = '1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pattern extremes, every action, absent rows, sense extremes
		send_item(ACT_WRITE, 3'd0, 12'h000, 12'hFFF);
		send_item(ACT_WRITE, 3'd0, 12'hFFF, 12'h000);
		send_item(ACT_WRITE, 3'd1, 12'hA5A, 12'hFFF);
		send_item(ACT_WRITE, 3'd2, 12'h5A5, 12'hFFF);
		send_item(ACT_WRITE, 3'd3, 12'h001, 12'hFFF);
		send_item(ACT_WRITE, 3'd4, 12'h800, 12'hFFF);
		send_item(ACT_WRITE, 3'd5, 12'hF0F, 12'hFFF);
		send_item(ACT_WRITE, 3'd6, 12'h0F0, 12'hFFF);
		send_item(ACT_WRITE, 3'd7, 12'hFFF, 12'hFFF);
		send_item(ACT_READ, 3'd0, 12'hFFF, 12'h000);
		send_item(ACT_READ, 3'd1, 12'h000, 12'hFFF);
		send_item(ACT_READ, 3'd2, 12'hFFF, 12'hFFF);
		send_item(ACT_READ, 3'd3, 12'h000, 12'h000);
		send_item(ACT_READ, 3'd7, 12'hFFF, 12'hFFF);
		send_item(ACT_UNUSED, 3'd0, 12'hFFF, 12'h000);
		send_item(ACT_TICK, 3'd7, 12'hFFF, 12'hFFF);
		send_item(ACT_WRITE, 3'd0, 12'h3C3, 12'hFFF);

		total = 0;
		for (int p = 0; p < PLANS; p++)
			total += plan_items[p];

		// Random: sweep timing settings, mostly steady switch levels with occasional changes
		done = 0;
		for (int p = 0; p < PLANS; p++) begin
			drain();
			write_timing(plan_on[p], plan_gap[p], plan_settle[p]);
			for (int k = 0; k < plan_items[p]; k++) begin
				if (done * 3 < total) begin
					tx_idle_pct = 7;
					rx_idle_pct = 72;
				end else if (done * 3 < total * 2) begin
					tx_idle_pct = 72;
					rx_idle_pct = 7;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end

				// Press and release a few switches now and then
				if ($urandom_range(9) == 0)
					held_sense = held_sense ^ (COLUMNS'($urandom) & COLUMNS'($urandom));
				sense = ($urandom_range(19) == 0) ? COLUMNS'($urandom) : held_sense;

				roll = $urandom_range(99);
				if (roll < 40)
					act = ACT_TICK;
				else if (roll < 65)
					act = ACT_WRITE;
				else if (roll < 95)
					act = ACT_READ;
				else
					act = ACT_UNUSED;

				if (act == ACT_READ && $urandom_range(9) != 0)
					row = ROW_W'($urandom_range(SWITCH_ROWS - 1));
				else
					row = ROW_W'($urandom_range(7));

				roll = $urandom_range(9);
				if (roll == 0)
					bits = '0;
				else if (roll == 1)
					bits = '1;
				else
					bits = COLUMNS'($urandom);

				send_item(act, row, bits, sense);
				done++;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Scanner run: %0d commands (%0d LED writes, %0d switch reads, %0d to absent rows)",
			n_items, n_writes, n_reads, n_absent);
		$display("Timing swept over %0d settings, from zero-length phases to full 16-bit counts",
			n_settings);
		if (failures == 0 && waiting == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results missing", failures, waiting);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: front_panel_led_switch_scanner.f
src/fpls_pkg.sv
src/fpls_if.sv
src/fpls_scan_timer.sv
src/fpls_matrix_store.sv
src/fpls_out_buffer.sv
src/front_panel_led_switch_scanner.sv
verif/panel_scan_checker.sv
verif/front_panel_led_switch_scanner_test.sv
